// ----- rtl/vogi_pkg.sv -----
package vogi_pkg;

    // default grid geometry and inflation radius
    localparam int X_MAX_DEF   = 256;
    localparam int Y_MAX_DEF   = 256;
    localparam int Z_MAX_DEF   = 16;
    localparam int INFLATE_DEF = 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // size register widths and reset values
    localparam int SXY_W = 9;
    localparam int SZ_W  = 5;
    localparam logic [SXY_W-1:0] SIZE_X_RST = 9'd256;
    localparam logic [SXY_W-1:0] SIZE_Y_RST = 9'd256;
    localparam logic [SZ_W-1:0]  SIZE_Z_RST = 5'd16;

    // operation codes
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic occupied;
        logic applied;
        logic map_locked;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_YZ,
        ST_BASE,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic calc_yz;
        logic calc_base;
        logic read;
        logic sweep_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic centre_in;
        logic is_query;
        logic locked;
        logic sweep_last;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/vogi_ctrl.sv -----
module vogi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  vogi_pkg::t_status i_status,
    output vogi_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);

    vogi_pkg::t_state r_state;
    vogi_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vogi_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            vogi_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = vogi_pkg::ST_IDLE;
                end
            end
            vogi_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = vogi_pkg::ST_YZ;
                end
            end
            vogi_pkg::ST_YZ: begin
                o_cmd.calc_yz = 1'b1;
                n_state       = vogi_pkg::ST_BASE;
            end
            vogi_pkg::ST_BASE: begin
                o_cmd.calc_base = 1'b1;
                priority if (i_status.is_query) begin
                    n_state = vogi_pkg::ST_READ;
                end else if (i_status.centre_in && !i_status.locked) begin
                    n_state = vogi_pkg::ST_SWEEP;
                end else begin
                    n_state = vogi_pkg::ST_DONE;
                end
            end
            vogi_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = vogi_pkg::ST_DONE;
            end
            vogi_pkg::ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = vogi_pkg::ST_DONE;
                end
            end
            vogi_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = vogi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vogi_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/vogi_dp.sv -----
module vogi_dp #(
    parameter int X_MAX   = vogi_pkg::X_MAX_DEF,
    parameter int Y_MAX   = vogi_pkg::Y_MAX_DEF,
    parameter int Z_MAX   = vogi_pkg::Z_MAX_DEF,
    parameter int INFLATE = vogi_pkg::INFLATE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vogi_pkg::t_cmd                      i_cmd,
    output vogi_pkg::t_status                   o_status,
    input  vogi_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output vogi_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vogi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vogi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int GRID = X_MAX * Y_MAX * Z_MAX;
    localparam int AW   = (GRID > 1) ? $clog2(GRID) : 1;
    localparam int XY   = X_MAX * Y_MAX;
    localparam int DW   = (INFLATE > 0) ? $clog2(2 * INFLATE + 1) : 1;
    localparam int CW   = 17;

    // running address steps inside the inflation cube, modulo 2^AW
    localparam logic [AW-1:0] STEP_X = AW'(1);
    localparam logic [AW-1:0] STEP_Y = AW'(X_MAX - 2 * INFLATE);
    localparam logic [AW-1:0] STEP_Z = AW'(XY - 2 * INFLATE * X_MAX - 2 * INFLATE);
    localparam logic [AW-1:0] CORNER = AW'(-(INFLATE * (1 + X_MAX + XY)));
    localparam logic [DW-1:0] D_LAST = DW'(2 * INFLATE);
    localparam logic [AW-1:0] A_LAST = AW'(GRID - 1);

    logic [vogi_pkg::SXY_W-1:0] r_size_x;
    logic [vogi_pkg::SXY_W-1:0] r_size_y;
    logic [vogi_pkg::SZ_W-1:0]  r_size_z;
    vogi_pkg::t_in_item         r_item;
    logic [AW-1:0]              r_yz;
    logic [AW-1:0]              r_addr;
    logic [AW-1:0]              r_clr_addr;
    logic [DW-1:0]              r_dx;
    logic [DW-1:0]              r_dy;
    logic [DW-1:0]              r_dz;
    logic                       r_rdata;
    logic                       r_locked;
    logic                       r_out_valid;
    vogi_pkg::t_out_item        r_out_data;
    logic                       r_mem [GRID];

    logic signed [CW-1:0] used_x;
    logic signed [CW-1:0] used_y;
    logic signed [CW-1:0] used_z;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;
    logic                 centre_in;
    logic                 nb_in;
    logic                 out_free;

    function automatic logic axis_in(input logic signed [CW-1:0] v,
                                     input logic signed [CW-1:0] used);
        return (v >= 0) && (v < used);
    endfunction

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= vogi_pkg::SIZE_X_RST;
            r_size_y <= vogi_pkg::SIZE_Y_RST;
            r_size_z <= vogi_pkg::SIZE_Z_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vogi_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                vogi_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                vogi_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data[vogi_pkg::SZ_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes in use, saturated at the grid capacity
    always_comb begin
        used_x = (CW'(r_size_x) > CW'(X_MAX)) ? CW'(X_MAX) : CW'(r_size_x);
        used_y = (CW'(r_size_y) > CW'(Y_MAX)) ? CW'(Y_MAX) : CW'(r_size_y);
        used_z = (CW'(r_size_z) > CW'(Z_MAX)) ? CW'(Z_MAX) : CW'(r_size_z);
    end

    // centre and current neighbor coordinates with bounds checks
    always_comb begin
        cx        = CW'(r_item.cell_x);
        cy        = CW'(r_item.cell_y);
        cz        = CW'(r_item.cell_z);
        nx        = cx + CW'(r_dx) - CW'(INFLATE);
        ny        = cy + CW'(r_dy) - CW'(INFLATE);
        nz        = cz + CW'(r_dz) - CW'(INFLATE);
        centre_in = axis_in(cx, used_x) && axis_in(cy, used_y) && axis_in(cz, used_z);
        nb_in     = axis_in(nx, used_x) && axis_in(ny, used_y) && axis_in(nz, used_z);
    end

    // item capture and address arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.calc_yz) begin
            r_yz <= AW'(r_item.cell_y) + AW'(Y_MAX) * AW'(r_item.cell_z);
        end
        priority if (i_cmd.calc_base) begin
            r_addr <= AW'(r_item.cell_x) + AW'(X_MAX) * r_yz
                      + ((r_item.operation == vogi_pkg::OP_QUERY) ? '0 : CORNER);
            r_dx   <= '0;
            r_dy   <= '0;
            r_dz   <= '0;
        end else if (i_cmd.sweep_step) begin
            // x innermost, then y, then z
            priority if (r_dx != D_LAST) begin
                r_dx   <= r_dx + DW'(1);
                r_addr <= r_addr + STEP_X;
            end else if (r_dy != D_LAST) begin
                r_dx   <= '0;
                r_dy   <= r_dy + DW'(1);
                r_addr <= r_addr + STEP_Y;
            end else begin
                r_dx   <= '0;
                r_dy   <= '0;
                r_dz   <= r_dz + DW'(1);
                r_addr <= r_addr + STEP_Z;
            end
        end
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // occupancy memory, one bit per voxel
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.sweep_step && nb_in) begin
            r_mem[r_addr] <= 1'b1;
        end
        if (i_cmd.read) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // lock flag and result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
            if (r_item.operation == vogi_pkg::OP_MARK && r_item.last_point) begin
                r_locked <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_item.operation == vogi_pkg::OP_QUERY) begin
                r_out_data.occupied <= !centre_in || r_rdata;
                r_out_data.applied  <= 1'b0;
            end else begin
                r_out_data.occupied <= 1'b0;
                r_out_data.applied  <= centre_in && !r_locked;
            end
            r_out_data.map_locked <= r_locked ||
                (r_item.operation == vogi_pkg::OP_MARK && r_item.last_point);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // status to controller
    always_comb begin
        o_status.clr_last   = (r_clr_addr == A_LAST);
        o_status.centre_in  = centre_in;
        o_status.is_query   = (r_item.operation == vogi_pkg::OP_QUERY);
        o_status.locked     = r_locked;
        o_status.sweep_last = (r_dx == D_LAST) && (r_dy == D_LAST) && (r_dz == D_LAST);
        o_status.out_free   = out_free;
    end

endmodule

// ----- rtl/voxel_occupancy_grid_inflate_top.sv -----
// One-bit 3-D occupancy grid with cube inflation. After reset the whole grid is
// swept clear, one voxel a cycle, with input ready low; configuration writes
// are taken at any time. Each item then gives exactly one result. A query
// goes through the address multiply in two steps and one registered memory
// read before its result. A mark whose centre is inside the grid on an open
// map writes the inflation cube one voxel per cycle through the single
// memory write port; any other mark goes straight to its result. The next
// input transfer is taken while a result still waits in the output register;
// that item then holds in its last cycle until the waiting result is taken.
module voxel_occupancy_grid_inflate_top #(
    parameter int X_MAX   = vogi_pkg::X_MAX_DEF,
    parameter int Y_MAX   = vogi_pkg::Y_MAX_DEF,
    parameter int Z_MAX   = vogi_pkg::Z_MAX_DEF,
    parameter int INFLATE = vogi_pkg::INFLATE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  vogi_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output vogi_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vogi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vogi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    vogi_pkg::t_cmd    cmd;
    vogi_pkg::t_status status;

    // sequencer
    vogi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // grid memory, address arithmetic and result register
    vogi_dp #(
        .X_MAX   (X_MAX),
        .Y_MAX   (Y_MAX),
        .Z_MAX   (Z_MAX),
        .INFLATE (INFLATE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- rtl/vogi_chk.sv -----
module vogi_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input vogi_pkg::t_out_item             o_out_data
);

    logic r_lock_seen;

    // remember a locked map seen on any result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_seen <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out_data.map_locked) begin
            r_lock_seen <= 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a mark never reports occupied and a query never reports applied; checked as never both set
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.applied && o_out_data.occupied))
        else $error("applied and occupied both set");

    // lock is sticky across results
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_lock_seen |-> o_out_data.map_locked && !o_out_data.applied)
        else $error("map unlocked or mark applied after lock");

    // no input taken in the cycle after reset, clearing pass runs first
    a_clear_first: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready during grid clear");

endmodule

bind voxel_occupancy_grid_inflate_top vogi_chk u_vogi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import vogi_pkg::*;

    localparam int GX          = X_MAX_DEF;
    localparam int GY          = Y_MAX_DEF;
    localparam int GZ          = Z_MAX_DEF;
    localparam int RADIUS      = INFLATE_DEF;
    // clearing sweep plus the slowest item stream, several times over
    localparam int CYCLE_LIMIT = 4_000_000;
    // longest item, a full inflation sweep, plus margin
    localparam int SETTLE      = 40;

    // occupancy predictor with its own copy of the grid, lock and sizes
    class grid_scoreboard;
        bit          occ_map[int unsigned];
        bit          locked;
        int          used_x;
        int          used_y;
        int          used_z;
        t_out_item   pending[$];
        int          errors;

        function new();
            locked = 1'b0;
            used_x = GX;
            used_y = GY;
            used_z = GZ;
            errors = 0;
        endfunction

        // size in use saturates at the grid dimension
        function void set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            int v;
            case (idx)
                REG_SIZE_X: begin
                    v = int'(val[SXY_W-1:0]);
                    used_x = (v > GX) ? GX : v;
                end
                REG_SIZE_Y: begin
                    v = int'(val[SXY_W-1:0]);
                    used_y = (v > GY) ? GY : v;
                end
                REG_SIZE_Z: begin
                    v = int'(val[SZ_W-1:0]);
                    used_z = (v > GZ) ? GZ : v;
                end
                default: ;
            endcase
        endfunction

        function bit off_grid(int x, int y, int z);
            return (x < 0 || x >= used_x || y < 0 || y >= used_y || z < 0 || z >= used_z);
        endfunction

        function int unsigned voxel_addr(int x, int y, int z);
            return unsigned'(int'(x) + GX * (int'(y) + GY * int'(z)));
        endfunction

        // work out the result of one accepted item and update the grid
        function void note_input(t_in_item it);
            int        cx;
            int        cy;
            int        cz;
            t_out_item res;
            cx  = int'($signed(it.cell_x));
            cy  = int'($signed(it.cell_y));
            cz  = int'($signed(it.cell_z));
            res = '0;
            if (it.operation == OP_QUERY) begin
                if (off_grid(cx, cy, cz))
                    res.occupied = 1'b1;
                else
                    res.occupied = 1'(occ_map.exists(voxel_addr(cx, cy, cz)));
            end else if (!locked) begin
                if (!off_grid(cx, cy, cz)) begin
                    res.applied = 1'b1;
                    // set the inflation cube, skipping voxels off the grid
                    for (int i = -RADIUS; i <= RADIUS; i++)
                        for (int j = -RADIUS; j <= RADIUS; j++)
                            for (int k = -RADIUS; k <= RADIUS; k++)
                                if (!off_grid(cx + i, cy + j, cz + k))
                                    occ_map[voxel_addr(cx + i, cy + j, cz + k)] = 1'b1;
                end
                if (it.last_point)
                    locked = 1'b1;
            end
            res.map_locked = locked;
            pending.insert(pending.size(), res);
        endfunction

        task flag_error(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // compare one result transfer with the oldest expectation
        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                flag_error($sformatf("unexpected result occ=%0b app=%0b lock=%0b",
                                     got.occupied, got.applied, got.map_locked));
            end else begin
                want = pending.pop_front();
                if (got.occupied !== want.occupied || got.applied !== want.applied ||
                    got.map_locked !== want.map_locked)
                    flag_error($sformatf("got occ=%0b app=%0b lock=%0b, want %0b %0b %0b",
                                         got.occupied, got.applied, got.map_locked,
                                         want.occupied, want.applied, want.map_locked));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    grid_scoreboard grid = new();
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_cycles    = 0;
    int             cycle_cnt      = 0;

    voxel_occupancy_grid_inflate_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            grid.check_result(o_out_data);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic op, int x, int y, int z, logic last);
        t_in_item it;
        it.operation  = op;
        it.cell_x     = 16'(x);
        it.cell_y     = 16'(y);
        it.cell_z     = 16'(z);
        it.last_point = last;
        return it;
    endfunction

    // mostly near the low corner or the far edge, some full-range noise
    function automatic logic signed [15:0] pick_coord(int dim);
        int r;
        int hi;
        r  = $urandom_range(0, 99);
        hi = ((dim < 10) ? dim : 10) + 1;
        if (r < 70)
            return 16'($urandom_range(0, hi + 2) - 2);
        else if (r < 85)
            return 16'(dim - 3 + $urandom_range(0, 4));
        else
            return 16'($urandom);
    endfunction

    // one input transfer, with random gaps before it
    task automatic push_item(t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        grid.note_input(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        grid.set_size(idx, val);
    endtask

    task automatic apply_sizes(int sx, int sy, int sz);
        write_reg(REG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(REG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(REG_SIZE_Z, CFG_DATA_W'(sz));
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every expected result has come back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (grid.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // random marks and queries; marks only lock when allowed
    task automatic run_random(int count, bit allow_lock);
        t_in_item it;
        for (int n = 0; n < count; n++) begin
            it.operation  = $urandom_range(0, 1) ? OP_QUERY : OP_MARK;
            it.cell_x     = pick_coord(grid.used_x);
            it.cell_y     = pick_coord(grid.used_y);
            it.cell_z     = pick_coord(grid.used_z);
            it.last_point = (it.operation == OP_QUERY || allow_lock) ?
                            1'($urandom_range(0, 1)) : 1'b0;
            push_item(it);
        end
    endtask

    initial begin
        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset sizes
        set_idling(0, 0);
        push_item(make_item(OP_QUERY, 0, 0, 0, 1'b1));
        push_item(make_item(OP_MARK, 0, 0, 0, 1'b0));
        push_item(make_item(OP_QUERY, 1, 1, 1, 1'b0));
        push_item(make_item(OP_QUERY, 2, 1, 1, 1'b0));
        push_item(make_item(OP_QUERY, -1, 0, 0, 1'b0));
        push_item(make_item(OP_MARK, 255, 255, 15, 1'b0));
        push_item(make_item(OP_QUERY, 254, 254, 14, 1'b0));
        push_item(make_item(OP_QUERY, 256, 0, 0, 1'b0));
        push_item(make_item(OP_MARK, -1, 5, 5, 1'b0));
        push_item(make_item(OP_QUERY, 0, 5, 5, 1'b0));
        push_item(make_item(OP_QUERY, -32768, -32768, -32768, 1'b0));
        push_item(make_item(OP_QUERY, 32767, 32767, 32767, 1'b1));
        push_item(make_item(OP_MARK, 32767, -32768, 0, 1'b0));
        push_item(make_item(OP_MARK, 100, 0, 7, 1'b0));
        push_item(make_item(OP_QUERY, 101, 1, 8, 1'b0));
        drain();

        // zero sizes: everything is off the grid
        apply_sizes(0, 0, 0);
        push_item(make_item(OP_MARK, 0, 0, 0, 1'b0));
        push_item(make_item(OP_QUERY, 0, 0, 0, 1'b0));
        run_random(30, 1'b0);
        drain();

        // oversized registers saturate at the grid dimensions
        apply_sizes(511, 511, 31);
        push_item(make_item(OP_QUERY, 255, 255, 15, 1'b0));
        push_item(make_item(OP_QUERY, 256, 255, 15, 1'b0));
        push_item(make_item(OP_QUERY, 255, 256, 15, 1'b0));
        push_item(make_item(OP_QUERY, 255, 255, 16, 1'b0));
        run_random(20, 1'b0);
        drain();

        // small grid, back-to-back transfers
        apply_sizes(8, 6, 3);
        run_random(250, 1'b0);
        drain();

        // single voxel grid, sender gaps
        set_idling(55, 0);
        apply_sizes(1, 1, 1);
        run_random(100, 1'b0);
        drain();

        // full x range with thin y, receiver stalls
        set_idling(0, 55);
        apply_sizes(256, 5, 16);
        run_random(200, 1'b0);
        drain();

        // both sides idle, long receiver hold-off to back up the input
        set_idling(16, 16);
        apply_sizes(12, 12, 4);
        hold_cycles = 400;
        run_random(250, 1'b0);
        drain();

        // resize over existing bits
        set_idling(0, 55);
        apply_sizes(3, 200, 2);
        run_random(200, 1'b0);
        drain();

        // lock through a last point off the grid, then marks change nothing
        set_idling(16, 16);
        apply_sizes(8, 6, 3);
        push_item(make_item(OP_MARK, -5, 0, 0, 1'b1));
        push_item(make_item(OP_MARK, 1, 1, 1, 1'b0));
        push_item(make_item(OP_QUERY, 1, 1, 1, 1'b0));
        run_random(100, 1'b1);
        drain();

        if (grid.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
